@@ rtl/core/shga_pkg.sv @@
// ----------------------------------------------------------------------------
// shga_pkg
// Types, command and status codes, and saturating Q23.40 add shared by the
// sparse Hessian / gradient assembly unit and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package shga_pkg;

	typedef struct packed {
		logic [3:0]         cmd;
		logic [12:0]        first_index;
		logic [12:0]        second_index;
		logic [13:0]        third_index;
		logic signed [63:0] addend;
	} req_t;

	typedef struct packed {
		logic signed [63:0] read_value;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [3:0] {
		CMD_CLEAR_MAP  = 4'd0,
		CMD_MAP_VERTEX = 4'd1,
		CMD_SET_ROW    = 4'd2,
		CMD_SET_ENTRY  = 4'd3,
		CMD_CLEAR_SUMS = 4'd4,
		CMD_ADD_F      = 4'd5,
		CMD_ADD_G      = 4'd6,
		CMD_ADD_H      = 4'd7,
		CMD_READ_G     = 4'd8,
		CMD_READ_H     = 4'd9,
		CMD_READ_F     = 4'd10
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_IGNORED   = 2'd1,
		STATUS_SATURATED = 2'd2
	} status_t;

	// {overflow flag, saturated sum}
	function automatic logic [64:0] sat_add(input logic [63:0] acc, input logic [63:0] addend);
		logic [63:0] r;
		r = acc + addend;
		if (acc[63] == addend[63] && r[63] != acc[63]) begin
			return {1'b1, acc[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
		end
		return {1'b0, r};
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/shga_req_if.sv @@
// ----------------------------------------------------------------------------
// shga_req_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface shga_req_if;
	logic               valid;
	logic               ready;
	shga_pkg::req_t     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/shga_rsp_if.sv @@
// ----------------------------------------------------------------------------
// shga_rsp_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface shga_rsp_if;
	logic               valid;
	logic               ready;
	shga_pkg::rsp_t     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sparse_hessian_gradient_assembly_unit.sv @@
// ----------------------------------------------------------------------------
// sparse_hessian_gradient_assembly_unit
// Accumulates function, gradient and sparse lower-triangular Hessian
// contributions (saturating Q23.40) through a vertex-to-unknown map.
// A gradient add maps the vertex, then reads and writes the sum. A Hessian
// add maps both vertices and reads the row; a diagonal add uses the row's last
// entry, an off-diagonal one binary-searches the row's entries by column
// through dependent entry table reads, then reads and writes the slot's sum.
// One command at a time.
// Clear map / clear sums sweep max(VERTICES,UNKNOWNS,NONZEROS) addresses.
// Reset: the same sweep runs after arst_n releases (no command taken meanwhile).
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_hessian_gradient_assembly_unit #(
	parameter int VERTICES = 1024,
	parameter int UNKNOWNS = 1024,
	parameter int NONZEROS = 8192
) (
	input  logic       clk,
	input  logic       arst_n,
	shga_req_if.sink   req,
	shga_rsp_if.source rsp
);
	import shga_pkg::*;

	localparam int VAW       = $clog2(VERTICES);
	localparam int UW        = $clog2(UNKNOWNS);
	localparam int NZW       = $clog2(NONZEROS);
	localparam int VU_MAX    = (VERTICES > UNKNOWNS) ? VERTICES : UNKNOWNS;
	localparam int CLR_DEPTH = (VU_MAX > NONZEROS) ? VU_MAX : NONZEROS;
	localparam int CW        = $clog2(CLR_DEPTH);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_G_LOOK, ST_G_ADD, ST_H_LOOKA, ST_H_LOOKB,
		ST_H_ROW, ST_H_PROBE, ST_H_CMP, ST_H_SLOT, ST_H_ADD, ST_RD_WAIT, ST_RESP
	} state_t;

	state_t state_q;

	// latched command
	logic [3:0]  cmd_q;
	logic [12:0] a_q, b_q;
	logic [13:0] c_q;
	logic [63:0] add_q;

	// Hessian walk
	logic [UW-1:0]  n_q, col_q;
	logic           diag_q;
	logic [NZW-1:0] s_q, t_q, m_q, slot_q;

	// sweep
	logic [CW-1:0] clr_idx_q;
	logic          clr_map_q, clr_sums_q, clr_reply_q;

	logic [63:0] fsum_q;
	logic [63:0] res_value_q;
	logic [1:0]  res_status_q;
	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic [1:0]  out_status_q;

	// memory ports
	logic             vm_we, row_we, ent_we, grad_we, hess_we;
	logic [VAW-1:0]   vm_waddr, vm_raddr;
	logic [UW-1:0]    row_waddr, row_raddr, grad_waddr, grad_raddr;
	logic [NZW-1:0]   ent_waddr, ent_raddr, hess_waddr, hess_raddr;
	logic [UW:0]      vm_wdata, vm_rdata;
	logic [2*NZW:0]   row_wdata, row_rdata;
	logic [12+NZW:0]  ent_wdata, ent_rdata;
	logic [63:0]      grad_wdata, grad_rdata, hess_wdata, hess_rdata;

	shga_ram #(.WIDTH(UW+1), .DEPTH(VERTICES)) u_vmap (
		.clk(clk), .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
		.raddr(vm_raddr), .rdata(vm_rdata));
	shga_ram #(.WIDTH(2*NZW+1), .DEPTH(UNKNOWNS)) u_row (
		.clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
		.raddr(row_raddr), .rdata(row_rdata));
	shga_ram #(.WIDTH(13+NZW), .DEPTH(NONZEROS)) u_entry (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.raddr(ent_raddr), .rdata(ent_rdata));
	shga_ram #(.WIDTH(64), .DEPTH(UNKNOWNS)) u_grad (
		.clk(clk), .we(grad_we), .waddr(grad_waddr), .wdata(grad_wdata),
		.raddr(grad_raddr), .rdata(grad_rdata));
	shga_ram #(.WIDTH(64), .DEPTH(NONZEROS)) u_hess (
		.clk(clk), .we(hess_we), .waddr(hess_waddr), .wdata(hess_wdata),
		.raddr(hess_raddr), .rdata(hess_rdata));

	// Read-data fields
	logic            vm_valid;
	logic [UW-1:0]   vm_unk;
	logic [NZW-1:0]  row_first;
	logic [NZW:0]    row_count;
	logic [12:0]     ent_col;
	logic [NZW-1:0]  ent_slot;
	assign vm_valid  = vm_rdata[UW];
	assign vm_unk    = vm_rdata[UW-1:0];
	assign row_first = row_rdata[2*NZW:NZW+1];
	assign row_count = row_rdata[NZW:0];
	assign ent_col   = ent_rdata[12+NZW:NZW];
	assign ent_slot  = ent_rdata[NZW-1:0];

	// Order the pair: row is the larger unknown
	logic [UW-1:0] row_sel, col_sel;
	assign row_sel = (n_q > vm_unk) ? n_q : vm_unk;
	assign col_sel = (n_q > vm_unk) ? vm_unk : n_q;

	// Last entry of the row, clamped to the table end
	logic [NZW:0]   last_sum;
	logic [NZW-1:0] last_pos;
	assign last_sum = {1'b0, row_first} + row_count - (NZW+1)'(1);
	assign last_pos = (last_sum >= (NZW+1)'(NONZEROS)) ? NZW'(NONZEROS - 1)
		: last_sum[NZW-1:0];

	// Search step
	logic [NZW:0]   mid_sum;
	logic [NZW-1:0] mid;
	logic           go_low;
	logic [NZW-1:0] s_next, t_next;
	assign mid_sum = {1'b0, s_q} + {1'b0, t_q};
	assign mid     = mid_sum[NZW:1];
	assign go_low  = ent_col > 13'(col_q);
	assign s_next  = go_low ? s_q : m_q;
	assign t_next  = go_low ? m_q : t_q;

	// One saturating adder serves function, gradient and Hessian adds
	logic [63:0] acc_sel;
	logic [64:0] sum;
	always_comb begin
		unique case (state_q)
			ST_DISPATCH: acc_sel = fsum_q;
			ST_G_ADD:    acc_sel = grad_rdata;
			default:     acc_sel = hess_rdata;
		endcase
	end
	assign sum = sat_add(acc_sel, add_q);

	// Memory port control
	always_comb begin
		vm_we = 1'b0;    vm_waddr = '0;   vm_wdata = '0;   vm_raddr = '0;
		row_we = 1'b0;   row_waddr = '0;  row_wdata = '0;  row_raddr = '0;
		ent_we = 1'b0;   ent_waddr = '0;  ent_wdata = '0;  ent_raddr = '0;
		grad_we = 1'b0;  grad_waddr = '0; grad_wdata = '0; grad_raddr = '0;
		hess_we = 1'b0;  hess_waddr = '0; hess_wdata = '0; hess_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				vm_we      = clr_map_q && (32'(clr_idx_q) < VERTICES);
				vm_waddr   = clr_idx_q[VAW-1:0];
				grad_we    = clr_sums_q && (32'(clr_idx_q) < UNKNOWNS);
				grad_waddr = clr_idx_q[UW-1:0];
				hess_we    = clr_sums_q && (32'(clr_idx_q) < NONZEROS);
				hess_waddr = clr_idx_q[NZW-1:0];
			end
			ST_DISPATCH: begin
				unique case (cmd_t'(cmd_q))
					CMD_MAP_VERTEX: begin
						vm_we    = (32'(a_q) < VERTICES) && (32'(b_q) < UNKNOWNS);
						vm_waddr = a_q[VAW-1:0];
						vm_wdata = {1'b1, b_q[UW-1:0]};
					end
					CMD_SET_ROW: begin
						row_we    = (32'(a_q) < UNKNOWNS) && (32'(b_q) < NONZEROS)
							&& (32'(c_q) <= NONZEROS);
						row_waddr = a_q[UW-1:0];
						row_wdata = {b_q[NZW-1:0], c_q[NZW:0]};
					end
					CMD_SET_ENTRY: begin
						ent_we    = (32'(a_q) < NONZEROS) && (32'(c_q) < NONZEROS);
						ent_waddr = a_q[NZW-1:0];
						ent_wdata = {b_q, c_q[NZW-1:0]};
					end
					CMD_ADD_G, CMD_ADD_H: vm_raddr = a_q[VAW-1:0];
					CMD_READ_G: grad_raddr = a_q[UW-1:0];
					CMD_READ_H: hess_raddr = a_q[NZW-1:0];
					default: ;
				endcase
			end
			ST_G_LOOK:  grad_raddr = vm_unk;
			ST_G_ADD: begin
				grad_we    = 1'b1;
				grad_waddr = n_q;
				grad_wdata = sum[63:0];
			end
			ST_H_LOOKA: vm_raddr = b_q[VAW-1:0];
			ST_H_LOOKB: row_raddr = row_sel;
			ST_H_ROW:   ent_raddr = last_pos;
			ST_H_PROBE: ent_raddr = mid;
			ST_H_CMP:   ent_raddr = s_next;
			ST_H_SLOT:  hess_raddr = ent_slot;
			ST_H_ADD: begin
				hess_we    = 1'b1;
				hess_waddr = slot_q;
				hess_wdata = sum[63:0];
			end
			default: ;
		endcase
	end

	// Sequencer: one command from transfer in to result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			clr_map_q    <= 1'b1;
			clr_sums_q   <= 1'b1;
			clr_reply_q  <= 1'b0;
			fsum_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the result once it is taken, unless a new one replaces it
			if (out_valid_q && rsp.ready && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_idx_q == CW'(CLR_DEPTH - 1)) begin
						state_q <= clr_reply_q ? ST_RESP : ST_IDLE;
					end
					clr_idx_q <= clr_idx_q + CW'(1);
				end
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q        <= req.data.cmd;
						a_q          <= req.data.first_index;
						b_q          <= req.data.second_index;
						c_q          <= req.data.third_index;
						add_q        <= req.data.addend;
						res_value_q  <= '0;
						res_status_q <= STATUS_DONE;
						state_q      <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					state_q <= ST_RESP;
					unique case (cmd_t'(cmd_q))
						CMD_CLEAR_MAP, CMD_CLEAR_SUMS: begin
							clr_map_q   <= (cmd_t'(cmd_q) == CMD_CLEAR_MAP);
							clr_sums_q  <= (cmd_t'(cmd_q) == CMD_CLEAR_SUMS);
							clr_reply_q <= 1'b1;
							clr_idx_q   <= '0;
							state_q     <= ST_CLEAR;
							if (cmd_t'(cmd_q) == CMD_CLEAR_SUMS) begin
								fsum_q <= '0;
							end
						end
						CMD_MAP_VERTEX: begin
							if (!((32'(a_q) < VERTICES) && (32'(b_q) < UNKNOWNS))) begin
								res_status_q <= STATUS_IGNORED;
							end
						end
						CMD_SET_ROW: begin
							if (!((32'(a_q) < UNKNOWNS) && (32'(b_q) < NONZEROS)
								&& (32'(c_q) <= NONZEROS))) begin
								res_status_q <= STATUS_IGNORED;
							end
						end
						CMD_SET_ENTRY: begin
							if (!((32'(a_q) < NONZEROS) && (32'(c_q) < NONZEROS))) begin
								res_status_q <= STATUS_IGNORED;
							end
						end
						CMD_ADD_F: begin
							fsum_q <= sum[63:0];
							if (sum[64]) begin
								res_status_q <= STATUS_SATURATED;
							end
						end
						CMD_ADD_G: begin
							if (32'(a_q) < VERTICES) begin
								state_q <= ST_G_LOOK;
							end else begin
								res_status_q <= STATUS_IGNORED;
							end
						end
						CMD_ADD_H: begin
							if ((32'(a_q) < VERTICES) && (32'(b_q) < VERTICES)) begin
								state_q <= ST_H_LOOKA;
							end else begin
								res_status_q <= STATUS_IGNORED;
							end
						end
						CMD_READ_G: begin
							if (32'(a_q) < UNKNOWNS) begin
								state_q <= ST_RD_WAIT;
							end else begin
								res_status_q <= STATUS_IGNORED;
							end
						end
						CMD_READ_H: begin
							if (32'(a_q) < NONZEROS) begin
								state_q <= ST_RD_WAIT;
							end else begin
								res_status_q <= STATUS_IGNORED;
							end
						end
						CMD_READ_F: res_value_q <= fsum_q;
						default: res_status_q <= STATUS_IGNORED;
					endcase
				end
				ST_G_LOOK: begin
					if (vm_valid) begin
						n_q     <= vm_unk;
						state_q <= ST_G_ADD;
					end else begin
						res_status_q <= STATUS_IGNORED;
						state_q      <= ST_RESP;
					end
				end
				ST_G_ADD: begin
					if (sum[64]) begin
						res_status_q <= STATUS_SATURATED;
					end
					state_q <= ST_RESP;
				end
				ST_H_LOOKA: begin
					if (vm_valid) begin
						n_q     <= vm_unk;
						state_q <= ST_H_LOOKB;
					end else begin
						res_status_q <= STATUS_IGNORED;
						state_q      <= ST_RESP;
					end
				end
				ST_H_LOOKB: begin
					if (vm_valid) begin
						col_q   <= col_sel;
						diag_q  <= (n_q == vm_unk);
						state_q <= ST_H_ROW;
					end else begin
						res_status_q <= STATUS_IGNORED;
						state_q      <= ST_RESP;
					end
				end
				ST_H_ROW: begin
					if (row_count == '0 || 32'(row_first) >= NONZEROS) begin
						res_status_q <= STATUS_IGNORED;
						state_q      <= ST_RESP;
					end else begin
						s_q     <= row_first;
						t_q     <= last_pos;
						// diagonal: slot of the last entry is already on its way
						state_q <= diag_q ? ST_H_SLOT : ST_H_PROBE;
					end
				end
				ST_H_PROBE: begin
					m_q     <= mid;
					state_q <= ST_H_CMP;
				end
				ST_H_CMP: begin
					s_q <= s_next;
					t_q <= t_next;
					// narrow until the bracket is one entry wide
					state_q <= ((t_next - s_next) > NZW'(1)) ? ST_H_PROBE : ST_H_SLOT;
				end
				ST_H_SLOT: begin
					if (32'(ent_slot) < NONZEROS) begin
						slot_q  <= ent_slot;
						state_q <= ST_H_ADD;
					end else begin
						res_status_q <= STATUS_IGNORED;
						state_q      <= ST_RESP;
					end
				end
				ST_H_ADD: begin
					if (sum[64]) begin
						res_status_q <= STATUS_SATURATED;
					end
					state_q <= ST_RESP;
				end
				ST_RD_WAIT: begin
					res_value_q <= (cmd_t'(cmd_q) == CMD_READ_G) ? grad_rdata : hess_rdata;
					state_q     <= ST_RESP;
				end
				ST_RESP: begin
					// hold until the result register is free or being taken
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= res_value_q;
						out_status_q <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready            = (state_q == ST_IDLE);
	assign rsp.valid            = out_valid_q;
	assign rsp.data.read_value  = out_value_q;
	assign rsp.data.status      = out_status_q;

`ifndef SYNTH
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !req.ready)
		else $error("command taken during clearing sweep");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second command taken while one is in flight");
	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_H_CMP |-> s_q <= t_q)
		else $error("search bracket inverted");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_status_q == STATUS_DONE || out_status_q == STATUS_IGNORED
			|| out_status_q == STATUS_SATURATED))
		else $error("bad status code");
`endif

endmodule

`default_nettype wire

@@ rtl/core/shga_ram.sv @@
// ----------------------------------------------------------------------------
// shga_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module shga_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
